FILE: rtl/core/mono_framebuffer_raster_engine_macros.svh
// Assertion macros shared by the checker of the raster engine.
// Depends on nothing; the including scope provides clk and rst.
`ifndef MONO_FRAMEBUFFER_RASTER_ENGINE_MACROS_SVH
`define MONO_FRAMEBUFFER_RASTER_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MFRE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mfre assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MFRE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mfre assertion failed");

`endif

FILE: rtl/core/mfre_pkg.sv
// Package of the monochrome framebuffer raster engine: geometry, widths,
// request codes, sequencer states and the merge control struct. No dependencies.
`timescale 1ns / 1ps

package mfre_pkg;

  localparam int WORDS_PER_ROW = 20;
  localparam int SCREEN_WORDS  = 8000;

  localparam int DATA_W  = 32;
  localparam int REQ_W   = 3;
  localparam int X_W     = 10;
  localparam int Y_W     = 9;
  localparam int END_W   = 10;
  localparam int WADDR_W = 13;
  localparam int COUNT_W = 13;
  localparam int OFF_W   = 5;
  localparam int WIDX_W  = X_W - OFF_W;

  localparam int ADDR_W = $clog2(SCREEN_WORDS);
  localparam int LIN_MAX = (1 << END_W) * WORDS_PER_ROW + (1 << WIDX_W);
  localparam int LIN_W_RAW = $clog2(LIN_MAX);
  localparam int LIN_W = (LIN_W_RAW > WADDR_W) ? LIN_W_RAW : WADDR_W + 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_FILL_ONES  = 3'd0,
    REQ_FILL_ZEROS = 3'd1,
    REQ_PIXEL      = 3'd2,
    REQ_VLINE      = 3'd3,
    REQ_SPAN       = 3'd4,
    REQ_READ       = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_FETCH,
    ST_MERGE,
    ST_DONE
  } state_t;

  typedef struct packed {
    req_t             op;
    logic [OFF_W-1:0] x_off;
    logic [OFF_W-1:0] e_off;
    logic             first;
    logic             last;
    logic             multi;
    logic             color;
  } merge_ctl_t;

endpackage

FILE: rtl/core/mfre_req_if.sv
// Request channel of the raster engine: handshake and command payload.
// Depends on mfre_pkg for the field widths.
`timescale 1ns / 1ps

interface mfre_req_if;
  logic                          valid;
  logic                          ready;
  logic [mfre_pkg::REQ_W-1:0]    req_type;
  logic [mfre_pkg::X_W-1:0]      coord_x;
  logic [mfre_pkg::Y_W-1:0]      coord_y;
  logic [mfre_pkg::END_W-1:0]    end_coord;
  logic                          color;
  logic [mfre_pkg::WADDR_W-1:0]  word_addr;

  modport source (output valid, req_type, coord_x, coord_y, end_coord, color, word_addr,
                  input ready);
  modport sink (input valid, req_type, coord_x, coord_y, end_coord, color, word_addr,
                output ready);
endinterface

FILE: rtl/core/mfre_rsp_if.sv
// Result channel of the raster engine: handshake, read word and write count.
// Depends on mfre_pkg for the field widths.
`timescale 1ns / 1ps

interface mfre_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [mfre_pkg::DATA_W-1:0]   read_data;
  logic [mfre_pkg::COUNT_W-1:0]  words_written;

  modport source (output valid, read_data, words_written, input ready);
  modport sink (input valid, read_data, words_written, output ready);
endinterface

FILE: rtl/core/mfre_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mfre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/mfre_merge.sv
// Word merge unit: builds the pixel, line or span mask and merges it into
// the fetched word. Depends on mfre_pkg.
`timescale 1ns / 1ps

module mfre_merge (
  input  mfre_pkg::merge_ctl_t          ctl,
  input  logic [mfre_pkg::DATA_W-1:0]   old_word,
  output logic [mfre_pkg::DATA_W-1:0]   new_word
);

  localparam logic [mfre_pkg::DATA_W-1:0] ONES = '1;
  localparam logic [mfre_pkg::DATA_W-1:0] MSB_BIT = {1'b1, {(mfre_pkg::DATA_W-1){1'b0}}};

  logic [mfre_pkg::DATA_W-1:0] bit_mask;
  logic [mfre_pkg::DATA_W-1:0] head_mask;
  logic [mfre_pkg::DATA_W-1:0] tail_mask;
  logic [mfre_pkg::DATA_W-1:0] span_mask;

  always_comb begin
    bit_mask  = MSB_BIT >> ctl.x_off;
    head_mask = ONES >> ctl.x_off;
    tail_mask = ONES >> ctl.e_off;
    priority if (!ctl.multi) begin
      span_mask = head_mask ^ tail_mask;
    end else if (ctl.first) begin
      span_mask = head_mask;
    end else if (ctl.last) begin
      span_mask = ~tail_mask;
    end else begin
      span_mask = ONES;
    end

    case (ctl.op)
      mfre_pkg::REQ_PIXEL: new_word = (old_word & ~bit_mask) | (ctl.color ? bit_mask : '0);
      mfre_pkg::REQ_VLINE: new_word = old_word | bit_mask;
      mfre_pkg::REQ_SPAN:  new_word = old_word | span_mask;
      default:             new_word = old_word;
    endcase
  end

endmodule

FILE: rtl/core/mono_framebuffer_raster_engine.sv
// Top level of the monochrome framebuffer raster engine: command sequencer,
// shared address adder, frame RAM and result register.
// Depends on mfre_pkg, mfre_req_if, mfre_rsp_if, mfre_ram and mfre_merge.
//
//   Channel | Direction | Payload
//   req     | in        | req_type, coord_x, coord_y, end_coord, color, word_addr
//   rsp     | out       | read_data, words_written
//
// Fills make one RAM write per cycle.
// Pixel, line and span commands run FETCH then MERGE for each word touched, since each
// word is a read-modify-write through the single registered read port; a read fetches only.
// After reset a clearing pass writes all SCREEN_WORDS (8000) words before req is ready.
// req is ready only while the sequencer is idle; a stalled result holds in rsp
// and the next command runs, waiting at its end until the result register is free.
`timescale 1ns / 1ps

module mono_framebuffer_raster_engine (
  input logic      clk,
  input logic      rst,
  mfre_req_if.sink req,
  mfre_rsp_if.source rsp
);

  localparam logic [mfre_pkg::LIN_W-1:0] LAST_WORD = mfre_pkg::LIN_W'(mfre_pkg::SCREEN_WORDS - 1);
  localparam logic [mfre_pkg::LIN_W-1:0] SCREEN_END = mfre_pkg::LIN_W'(mfre_pkg::SCREEN_WORDS);
  localparam logic [mfre_pkg::LIN_W-1:0] ROW_STEP = mfre_pkg::LIN_W'(mfre_pkg::WORDS_PER_ROW);
  localparam logic [mfre_pkg::LIN_W-1:0] ONE_STEP = mfre_pkg::LIN_W'(1);

  mfre_pkg::state_t state, state_next;
  mfre_pkg::req_t   op, op_next;

  logic [mfre_pkg::X_W-1:0]     cx, cx_next;
  logic [mfre_pkg::END_W-1:0]   ce, ce_next;
  logic                         col, col_next;
  logic [mfre_pkg::END_W-1:0]   row, row_next;
  logic [mfre_pkg::WIDX_W-1:0]  widx, widx_next;
  logic [mfre_pkg::WIDX_W-1:0]  wlast, wlast_next;
  logic [mfre_pkg::LIN_W-1:0]   lin, lin_next;
  logic [mfre_pkg::COUNT_W-1:0] count, count_next;

  logic                         rsp_valid, rsp_valid_next;
  logic [mfre_pkg::DATA_W-1:0]  rsp_rdata, rsp_rdata_next;
  logic [mfre_pkg::COUNT_W-1:0] rsp_count, rsp_count_next;

  logic [mfre_pkg::LIN_W-1:0]   lin_step;
  logic [mfre_pkg::LIN_W-1:0]   lin_sum;
  logic [mfre_pkg::LIN_W-1:0]   start_lin;
  logic                         in_range;
  logic                         multi;

  logic                         ram_wr_en;
  logic [mfre_pkg::ADDR_W-1:0]  ram_addr;
  logic [mfre_pkg::DATA_W-1:0]  ram_wr_data;
  logic                         ram_rd_en;
  logic [mfre_pkg::DATA_W-1:0]  ram_rd_data;
  logic [mfre_pkg::DATA_W-1:0]  merged;
  mfre_pkg::merge_ctl_t         mctl;

  assign lin_sum   = lin + lin_step;
  assign in_range  = lin < SCREEN_END;
  assign ram_addr  = lin[mfre_pkg::ADDR_W-1:0];
  assign multi     = cx[mfre_pkg::X_W-1:mfre_pkg::OFF_W] < ce[mfre_pkg::END_W-1:mfre_pkg::OFF_W];
  assign start_lin = mfre_pkg::LIN_W'(req.coord_y) * ROW_STEP
                   + mfre_pkg::LIN_W'(req.coord_x[mfre_pkg::X_W-1:mfre_pkg::OFF_W]);

  assign mctl.op    = op;
  assign mctl.x_off = cx[mfre_pkg::OFF_W-1:0];
  assign mctl.e_off = ce[mfre_pkg::OFF_W-1:0];
  assign mctl.first = widx == cx[mfre_pkg::X_W-1:mfre_pkg::OFF_W];
  assign mctl.last  = widx == ce[mfre_pkg::END_W-1:mfre_pkg::OFF_W];
  assign mctl.multi = multi;
  assign mctl.color = col;

  mfre_merge u_merge (
    .ctl      (mctl),
    .old_word (ram_rd_data),
    .new_word (merged)
  );

  mfre_ram #(
    .WIDTH (mfre_pkg::DATA_W),
    .DEPTH (mfre_pkg::SCREEN_WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_addr),
    .rd_data (ram_rd_data)
  );

  assign req.ready         = state == mfre_pkg::ST_IDLE;
  assign rsp.valid         = rsp_valid;
  assign rsp.read_data     = rsp_rdata;
  assign rsp.words_written = rsp_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mfre_pkg::ST_CLEAR;
      lin       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      lin       <= lin_next;
      rsp_valid <= rsp_valid_next;
    end
    op        <= op_next;
    cx        <= cx_next;
    ce        <= ce_next;
    col       <= col_next;
    row       <= row_next;
    widx      <= widx_next;
    wlast     <= wlast_next;
    count     <= count_next;
    rsp_rdata <= rsp_rdata_next;
    rsp_count <= rsp_count_next;
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    cx_next        = cx;
    ce_next        = ce;
    col_next       = col;
    row_next       = row;
    widx_next      = widx;
    wlast_next     = wlast;
    lin_next       = lin;
    count_next     = count;
    rsp_valid_next = rsp_valid && !rsp.ready;
    rsp_rdata_next = rsp_rdata;
    rsp_count_next = rsp_count;
    lin_step       = ONE_STEP;
    ram_wr_en      = 1'b0;
    ram_wr_data    = '0;
    ram_rd_en      = 1'b0;

    unique case (state)
      mfre_pkg::ST_CLEAR: begin
        ram_wr_en = 1'b1;
        if (lin == LAST_WORD) begin
          lin_next   = '0;
          state_next = mfre_pkg::ST_IDLE;
        end else begin
          lin_next = lin_sum;
        end
      end
      mfre_pkg::ST_IDLE: begin
        if (req.valid) begin
          op_next    = mfre_pkg::req_t'(req.req_type);
          cx_next    = req.coord_x;
          ce_next    = req.end_coord;
          col_next   = req.color;
          row_next   = mfre_pkg::END_W'(req.coord_y);
          widx_next  = req.coord_x[mfre_pkg::X_W-1:mfre_pkg::OFF_W];
          wlast_next = (req.coord_x[mfre_pkg::X_W-1:mfre_pkg::OFF_W]
                        < req.end_coord[mfre_pkg::END_W-1:mfre_pkg::OFF_W])
                     ? req.end_coord[mfre_pkg::END_W-1:mfre_pkg::OFF_W]
                     : req.coord_x[mfre_pkg::X_W-1:mfre_pkg::OFF_W];
          lin_next   = start_lin;
          count_next = '0;
          case (mfre_pkg::req_t'(req.req_type))
            mfre_pkg::REQ_FILL_ONES, mfre_pkg::REQ_FILL_ZEROS: begin
              lin_next   = '0;
              state_next = mfre_pkg::ST_FILL;
            end
            mfre_pkg::REQ_PIXEL, mfre_pkg::REQ_SPAN: begin
              state_next = mfre_pkg::ST_FETCH;
            end
            mfre_pkg::REQ_VLINE: begin
              state_next = (mfre_pkg::END_W'(req.coord_y) <= req.end_coord)
                         ? mfre_pkg::ST_FETCH : mfre_pkg::ST_DONE;
            end
            mfre_pkg::REQ_READ: begin
              lin_next   = mfre_pkg::LIN_W'(req.word_addr);
              state_next = mfre_pkg::ST_FETCH;
            end
            default: begin
              state_next = mfre_pkg::ST_DONE;
            end
          endcase
        end
      end
      mfre_pkg::ST_FILL: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = (op == mfre_pkg::REQ_FILL_ONES) ? '1 : '0;
        count_next  = count + mfre_pkg::COUNT_W'(1);
        if (lin == LAST_WORD) begin
          state_next = mfre_pkg::ST_DONE;
        end else begin
          lin_next = lin_sum;
        end
      end
      mfre_pkg::ST_FETCH: begin
        ram_rd_en  = 1'b1;
        state_next = (op == mfre_pkg::REQ_READ) ? mfre_pkg::ST_DONE : mfre_pkg::ST_MERGE;
      end
      mfre_pkg::ST_MERGE: begin
        ram_wr_en   = in_range;
        ram_wr_data = merged;
        count_next  = count + mfre_pkg::COUNT_W'(in_range);
        state_next  = mfre_pkg::ST_DONE;
        if (op == mfre_pkg::REQ_VLINE && row != ce) begin
          lin_step   = ROW_STEP;
          lin_next   = lin_sum;
          row_next   = row + mfre_pkg::END_W'(1);
          state_next = mfre_pkg::ST_FETCH;
        end else if (op == mfre_pkg::REQ_SPAN && widx != wlast) begin
          lin_next   = lin_sum;
          widx_next  = widx + mfre_pkg::WIDX_W'(1);
          state_next = mfre_pkg::ST_FETCH;
        end
      end
      mfre_pkg::ST_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_valid_next = 1'b1;
          rsp_rdata_next = (op == mfre_pkg::REQ_READ && in_range) ? ram_rd_data : '0;
          rsp_count_next = count;
          state_next     = mfre_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mfre_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/mfre_checker.sv
// Port-level checker of the raster engine and its bind to the top level.
// Depends on mfre_pkg and mono_framebuffer_raster_engine_macros.svh.
`timescale 1ns / 1ps
`include "mono_framebuffer_raster_engine_macros.svh"

module mfre_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [mfre_pkg::DATA_W-1:0]   read_data,
  input logic [mfre_pkg::COUNT_W-1:0]  words_written
);

  `MFRE_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(read_data) && $stable(words_written))
  `MFRE_ASSERT_NXT(a_busy_after_transfer, req_valid && req_ready, !req_ready)
  `MFRE_ASSERT_IMP(a_count_bound, rsp_valid, words_written <= mfre_pkg::COUNT_W'(mfre_pkg::SCREEN_WORDS))
  `MFRE_ASSERT_IMP(a_read_no_write, rsp_valid && words_written != '0, read_data == '0)

endmodule

bind mono_framebuffer_raster_engine mfre_checker u_mfre_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .read_data     (rsp.read_data),
  .words_written (rsp.words_written)
);
